[rtl/core/assert_macros.svh]
// Assertion helpers used by the top-level controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rlbf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbf_pkg
// Types, codes and constants of the RGB LED blink and fade controller.
// ----------------------------------------------------------------------------
package rlbf_pkg;

  localparam int MAX_FADE_STEPS = 64;
  localparam int TIMER_BITS     = 16;

  // floor(x/100) = (x * RECIP_28) >> 28 for x < 61008
  localparam logic [21:0] RECIP_28 = 22'd2684355;
  // floor(x/100) = (x * RECIP_32) >> 32 for x < 2^23
  localparam logic [25:0] RECIP_32 = 26'd42949673;

  // bits of |d|*100 fed to the step-width divider
  localparam int NUM_BITS = 15;

  // in_stall hold after a blink register write, while the on/off timing pipeline settles
  localparam logic [1:0] CFG_HOLD = 2'd3;

  typedef enum logic [1:0] {
    FUNC_SET    = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_FADE   = 2'd2,
    FUNC_UNUSED = 2'd3   // ignored: no result, no state change
  } func_t;

  typedef enum logic [1:0] {
    REG_COMMON_ANODE = 2'd0,
    REG_BLINK_PERIOD = 2'd1,
    REG_BLINK_DUTY   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [6:0] fade_steps;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_drive;
    logic [7:0] green_drive;
    logic [7:0] blue_drive;
    logic       lit_phase;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic step;
  } lane_cmd_t;

  typedef struct packed {
    logic ready;
  } lane_stat_t;

endpackage

[rtl/core/rgb_led_blink_fade_controller.sv]
`timescale 1ns / 1ps
// Set color and tick: written to the output register on acceptance, one item per cycle
// unless stalled. Fade of N steps: the item is accepted, the three color lanes divide
// and set up, then one result per cycle while the output does not stall.
// After a blink period or duty write, items wait for the on/off timing pipeline.
// Reset (synchronous, rst_n low): LED off, lit phase, duty 100, period 0.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rgb_led_blink_fade_controller
// RGB LED drive levels with blink timer and fade, three fade lanes merged.
// ----------------------------------------------------------------------------
module rgb_led_blink_fade_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rlbf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rlbf_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import rlbf_pkg::*;

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SETUP = 3'b010,
    S_RUN   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic        ca_r;
  logic [15:0] period_r;
  logic [6:0]  duty_r;
  logic [7:0]  sred_r, sgrn_r, sblu_r;
  logic [23:0] shown_r, shown_nxt;
  logic        phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] el_r, el_nxt, el_inc;
  logic [1:0]  hold_r;
  logic [6:0]  left_r, left_nxt;
  logic        out_valid_r;
  out_item_t   out_item_r;

  logic [15:0] on_ticks, off_ticks;
  lane_cmd_t   lcmd;
  lane_stat_t  st_r, st_g, st_b;
  logic [7:0]  lv_r, lv_g, lv_b;

  logic        can_load, accept, load, last;
  logic [6:0]  s_clamp;
  logic [23:0] color;
  logic        show_en;
  logic        steady, held;
  logic [15:0] n_period;
  logic [6:0]  n_duty;

  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && (hold_r == 2'd0) && !cfg_we && can_load);
  assign accept   = in_valid && !in_stall;
  assign steady   = (period_r == 16'd0) || (duty_r >= 7'd100);
  assign held     = (duty_r == 7'd0);
  assign el_inc   = (el_r == '1) ? el_r : el_r + 1'b1;

  assign s_clamp = (in_item.fade_steps == 7'd0) ? 7'd1 :
                   (in_item.fade_steps > 7'(MAX_FADE_STEPS)) ? 7'(MAX_FADE_STEPS) :
                   in_item.fade_steps;

  rlbf_blink_timing u_timing (
    .clk      (clk),
    .period   (period_r),
    .duty     (duty_r),
    .on_ticks (on_ticks),
    .off_ticks(off_ticks)
  );

  rlbf_fade_lane u_lane_r (
    .clk(clk), .rst_n(rst_n), .cmd(lcmd), .target(in_item.red_level),
    .saved(sred_r), .steps(s_clamp), .stat(st_r), .level(lv_r)
  );
  rlbf_fade_lane u_lane_g (
    .clk(clk), .rst_n(rst_n), .cmd(lcmd), .target(in_item.green_level),
    .saved(sgrn_r), .steps(s_clamp), .stat(st_g), .level(lv_g)
  );
  rlbf_fade_lane u_lane_b (
    .clk(clk), .rst_n(rst_n), .cmd(lcmd), .target(in_item.blue_level),
    .saved(sblu_r), .steps(s_clamp), .stat(st_b), .level(lv_b)
  );

  // item sequencing and the merge of lane levels into the shown color
  always_comb begin
    state_nxt  = state_r;
    shown_nxt  = shown_r;
    phase_nxt  = phase_r;
    el_nxt     = el_r;
    left_nxt   = left_r;
    load       = 1'b0;
    last       = 1'b1;
    show_en    = 1'b0;
    color      = {in_item.red_level, in_item.green_level, in_item.blue_level};
    lcmd.start = 1'b0;
    lcmd.step  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.func)
            FUNC_SET: begin
              load    = 1'b1;
              show_en = 1'b1;
            end
            FUNC_TICK: begin
              load = 1'b1;
              if (!steady) begin
                if (held) begin
                  shown_nxt = '0;
                  phase_nxt = 1'b0;
                  el_nxt    = '0;
                end else if (phase_r) begin
                  if (CW'(el_inc) >= CW'(on_ticks)) begin
                    shown_nxt = '0;
                    phase_nxt = 1'b0;
                    el_nxt    = '0;
                  end else begin
                    el_nxt = el_inc;
                  end
                end else if (CW'(el_inc) >= CW'(off_ticks)) begin
                  shown_nxt = {sred_r, sgrn_r, sblu_r};
                  phase_nxt = 1'b1;
                  el_nxt    = '0;
                end else begin
                  el_nxt = el_inc;
                end
              end
            end
            FUNC_FADE: begin
              lcmd.start = 1'b1;
              left_nxt   = s_clamp - 7'd1;
              state_nxt  = S_SETUP;
            end
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        if (st_r.ready && st_g.ready && st_b.ready) state_nxt = S_RUN;
      end
      S_RUN: begin
        color = {lv_r, lv_g, lv_b};
        last  = (left_r == 7'd0);
        if (can_load) begin
          load      = 1'b1;
          show_en   = 1'b1;
          lcmd.step = 1'b1;
          left_nxt  = left_r - 7'd1;
          if (last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (show_en) shown_nxt = color;
  end

  assign n_period = (cfg_index == REG_BLINK_PERIOD) ? cfg_wdata : period_r;
  assign n_duty   = (cfg_index == REG_BLINK_DUTY) ? cfg_wdata[6:0] : duty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ca_r        <= 1'b0;
      period_r    <= '0;
      duty_r      <= 7'd100;
      sred_r      <= '0;
      sgrn_r      <= '0;
      sblu_r      <= '0;
      shown_r     <= '0;
      phase_r     <= 1'b1;
      el_r        <= '0;
      hold_r      <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      out_valid_r <= load || (out_valid_r && out_stall);
      if (hold_r != 2'd0) hold_r <= hold_r - 2'd1;
      if (cfg_we && cfg_index == REG_COMMON_ANODE) begin
        ca_r <= cfg_wdata[0];
      end else if (cfg_we && (cfg_index == REG_BLINK_PERIOD ||
                              cfg_index == REG_BLINK_DUTY)) begin
        period_r <= n_period;
        duty_r   <= n_duty;
        el_r     <= '0;
        hold_r   <= CFG_HOLD;
        if (n_period == 16'd0 || n_duty >= 7'd100) begin
          shown_r <= {sred_r, sgrn_r, sblu_r};
          phase_r <= 1'b1;
        end else if (n_duty == 7'd0) begin
          shown_r <= '0;
          phase_r <= 1'b0;
        end else begin
          phase_r <= 1'b1;
        end
      end else begin
        shown_r <= shown_nxt;
        phase_r <= phase_nxt;
        el_r    <= el_nxt;
        if (show_en && color != 24'd0) begin
          sred_r <= color[23:16];
          sgrn_r <= color[15:8];
          sblu_r <= color[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r.red_drive   <= ca_r ? ~shown_nxt[23:16] : shown_nxt[23:16];
      out_item_r.green_drive <= ca_r ? ~shown_nxt[15:8] : shown_nxt[15:8];
      out_item_r.blue_drive  <= ca_r ? ~shown_nxt[7:0] : shown_nxt[7:0];
      out_item_r.lit_phase   <= phase_nxt;
      out_item_r.last_of_run <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_IMP(a_run_lanes_ready, clk, rst_n, state_r == S_RUN,
    st_r.ready && st_g.ready && st_b.ready, "fade step while a lane is not ready")
  `ASSERT_IMP(a_hold_stalls, clk, rst_n, hold_r != 2'd0, in_stall,
    "item taken before blink timing settled")
  `ASSERT_NXT(a_fade_to_setup, clk, rst_n, accept && in_item.func == FUNC_FADE,
    state_r == S_SETUP, "fade item did not start lane setup")
  `ASSERT_NXT(a_last_to_idle, clk, rst_n, state_r == S_RUN && load && last,
    state_r == S_IDLE && out_valid_r && out_item_r.last_of_run,
    "fade run did not end on its last step")

endmodule

[rtl/core/rlbf_fade_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbf_fade_lane
// One color channel of a fade: divides the difference into a step width,
// then walks the level from the far step down to the target, one per step.
// ----------------------------------------------------------------------------
module rlbf_fade_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  rlbf_pkg::lane_cmd_t cmd,
  input  logic [7:0]         target,
  input  logic [7:0]         saved,
  input  logic [6:0]         steps,
  output rlbf_pkg::lane_stat_t stat,
  output logic [7:0]         level
);
  import rlbf_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE  = 4'b0001,
    L_DIV   = 4'b0010,
    L_PREP  = 4'b0100,
    L_READY = 4'b1000
  } lane_state_t;

  lane_state_t state_r, state_nxt;

  logic                neg_r;
  logic [7:0]          tgt_r;
  logic [6:0]          s_r;
  logic [NUM_BITS-1:0] num_r;      // dividend, then quotient |w|
  logic [5:0]          rem_r;
  logic [3:0]          cnt_r;
  logic [2:0]          ph_r;
  logic [36:0]         prod_r;
  logic [7:0]          a_r;        // |w| / 100
  logic [6:0]          b_r;        // |w| % 100
  logic [12:0]         t1_r;
  logic [13:0]         qa_r;
  logic [13:0]         q_r;        // floor(i*|w|/100) for the current step
  logic [6:0]          r_r;

  logic [7:0]  mag;
  logic [6:0]  rem_sh;
  logic [7:0]  a_c;
  logic [6:0]  b_c;
  logic [15:0] v;

  assign mag    = (target < saved) ? saved - target : target - saved;
  assign rem_sh = {rem_r, num_r[NUM_BITS-1]};
  assign a_c    = prod_r[35:28];
  assign b_c    = 7'(num_r - NUM_BITS'(a_c) * NUM_BITS'(100));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE:  state_nxt = L_IDLE;
      L_DIV:   if (cnt_r == 4'd0) state_nxt = L_PREP;
      L_PREP:  if (ph_r == 3'd4) state_nxt = L_READY;
      L_READY: state_nxt = L_READY;
      default: state_nxt = L_IDLE;
    endcase
    if (cmd.start) state_nxt = L_DIV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      neg_r <= target < saved;
      tgt_r <= target;
      s_r   <= steps;
      num_r <= NUM_BITS'(mag) * NUM_BITS'(100);
      rem_r <= '0;
      cnt_r <= 4'(NUM_BITS - 1);
      ph_r  <= '0;
    end else begin
      unique case (state_r)
        L_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (rem_sh >= s_r) begin
            rem_r <= 6'(rem_sh - s_r);
            num_r <= {num_r[NUM_BITS-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[5:0];
            num_r <= {num_r[NUM_BITS-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 4'd1;
        end
        L_PREP: begin
          ph_r <= ph_r + 3'd1;
          case (ph_r)
            3'd0: prod_r <= 37'(num_r) * 37'(RECIP_28);
            3'd1: begin
              a_r <= a_c;
              b_r <= b_c;
            end
            3'd2: begin
              t1_r <= 13'(s_r - 7'd1) * 13'(b_r);
              qa_r <= 14'(14'(s_r - 7'd1) * 14'(a_r));
            end
            3'd3: prod_r <= 37'(t1_r) * 37'(RECIP_28);
            default: begin
              // start point: (steps-1)*|w| = 100*q + r
              q_r <= qa_r + 14'(prod_r[35:28]);
              r_r <= 7'(t1_r - 13'(prod_r[35:28]) * 13'd100);
            end
          endcase
        end
        L_READY: begin
          if (cmd.step) begin
            if (r_r < b_r) begin
              r_r <= r_r + 7'd100 - b_r;
              q_r <= q_r - 14'(a_r) - 14'd1;
            end else begin
              r_r <= r_r - b_r;
              q_r <= q_r - 14'(a_r);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign v = neg_r ? 16'(tgt_r) + 16'(q_r) : 16'(tgt_r) - 16'(q_r);

  always_comb begin
    if (neg_r) begin
      level = (v > 16'd255) ? 8'hFF : v[7:0];
    end else begin
      level = v[15] ? 8'h00 : v[7:0];
    end
  end

  assign stat.ready = (state_r == L_READY);

endmodule

[rtl/core/rlbf_blink_timing.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbf_blink_timing
// Lit and dark phase lengths from period and duty, three register stages.
// ----------------------------------------------------------------------------
module rlbf_blink_timing (
  input  logic        clk,
  input  logic [15:0] period,
  input  logic [6:0]  duty,
  output logic [15:0] on_ticks,
  output logic [15:0] off_ticks
);
  import rlbf_pkg::*;

  logic [6:0]  duty_eff;
  logic [22:0] p_on_r, p_off_r;
  logic [48:0] m_on_r, m_off_r;
  logic [15:0] on_r, off_r;

  assign duty_eff = (duty > 7'd100) ? 7'd100 : duty;

  always_ff @(posedge clk) begin
    p_on_r  <= 23'(period) * 23'(duty_eff);
    p_off_r <= 23'(period) * 23'(7'd100 - duty_eff);
    m_on_r  <= 49'(p_on_r) * 49'(RECIP_32);
    m_off_r <= 49'(p_off_r) * 49'(RECIP_32);
    on_r    <= m_on_r[47:32];
    off_r   <= m_off_r[47:32];
  end

  assign on_ticks  = on_r;
  assign off_ticks = off_r;

endmodule
